// ----- design/lrupr_pkg.sv -----
// Shared constants and response field layout for the LRU page replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package lrupr_pkg;

   localparam int REQ_PAGE_W      = 16;
   localparam int REQ_TDATA_W     = 16;
   localparam int FRAME_COUNT_W   = 4;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd4;
   localparam int FRAME_INDEX_W   = 3;
   localparam int CNT_W           = 32;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam int RSP_HIT_LSB     = 0;
   localparam int RSP_FRAME_LSB   = 1;
   localparam int RSP_EVV_LSB     = 4;
   localparam int RSP_EVP_LSB     = 5;
   localparam int RSP_FAULT_LSB   = 21;
   localparam int RSP_HITS_LSB    = 53;
   localparam int RSP_TSAT_LSB    = 85;
   localparam int RSP_USED_W      = 86;
   localparam int RSP_TDATA_W     = 88;

endpackage
`default_nettype wire

// ----- design/lru_page_replacement_unit.sv -----
// Top level of the timestamp-based LRU page replacement unit.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid / req_tready | req_tdata (page), req_tlast (last_in_run)
//  rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata (result fields)
//  csr     | in        | csr_wr_en               | csr_wr_data (frame_count)
//
// The request is taken in the idle state. The scan state then walks the frame memory,
// reading each active frame in turn, and the write-back state updates the chosen slot
// and loads the result into the output register.
// Synchronous reset clears valid bits, use clock, totals and the frame count (to 4).
// The result sits in an output register; a stalled rsp holds the write-back cycle only.
// A new reference is taken once the previous one has written back.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement_unit #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] page
   input  wire logic [lrupr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] hit, [3:1] frame_index, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] fault_count, [84:53] hit_total, [85] time_saturated, [87:86] zero
   output logic [lrupr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [lrupr_pkg::FRAME_COUNT_W-1:0] csr_wr_data
);

   localparam int FB    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW    = lrupr_pkg::CNT_W;
   localparam int MEM_W = CW + PAGE_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [MEM_W-1:0] mem [MAX_FRAMES];
   logic [MEM_W-1:0] rd_data_ff;
   logic [FB-1:0]    rd_addr;
   logic             mem_we;
   logic [FB-1:0]    wr_addr;
   logic [MEM_W-1:0] wr_data;

   logic [1:0]                           state_ff, state_in;
   logic [lrupr_pkg::FRAME_COUNT_W-1:0]  frame_count_ff, frame_count_in;
   logic [MAX_FRAMES-1:0]                valid_ff, valid_in;
   logic [CW-1:0]                        clock_ff, clock_in;
   logic [CW-1:0]                        faults_ff, faults_in;
   logic [CW-1:0]                        hits_ff, hits_in;
   logic [PAGE_BITS-1:0]                 page_ff, page_in;
   logic                                 last_ff, last_in;
   logic [FB-1:0]                        last_idx_ff, last_idx_in;
   logic [FB-1:0]                        idx_ff, idx_in;
   logic                                 hit_ff, hit_in;
   logic [FB-1:0]                        hit_idx_ff, hit_idx_in;
   logic                                 empty_ff, empty_in;
   logic [FB-1:0]                        empty_idx_ff, empty_idx_in;
   logic                                 best_set_ff, best_set_in;
   logic [CW-1:0]                        best_time_ff, best_time_in;
   logic [FB-1:0]                        best_idx_ff, best_idx_in;
   logic [PAGE_BITS-1:0]                 best_page_ff, best_page_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [lrupr_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [PAGE_BITS-1:0] entry_page;
   logic [CW-1:0]        entry_time;
   logic                 entry_valid;
   logic [FB-1:0]        active_last;
   logic [FB-1:0]        slot;
   logic [CW-1:0]        clock_next;
   logic [CW-1:0]        faults_next;
   logic [CW-1:0]        hits_next;
   logic                 out_free;
   logic                 req_xfer;

   assign entry_page  = rd_data_ff[PAGE_BITS-1:0];
   assign entry_time  = rd_data_ff[MEM_W-1:PAGE_BITS];
   assign entry_valid = valid_ff[idx_ff];
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      if (frame_count_ff == '0) begin
         active_last = '0;
      end else if (int'(frame_count_ff) > MAX_FRAMES) begin
         active_last = FB'(MAX_FRAMES - 1);
      end else begin
         active_last = FB'(frame_count_ff - 1'b1);
      end
   end

   always_comb begin
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (empty_ff) begin
         slot = empty_idx_ff;
      end else begin
         slot = best_idx_ff;
      end
      clock_next  = (clock_ff == lrupr_pkg::CNT_MAX) ? clock_ff : clock_ff + 1'b1;
      faults_next = (!hit_ff && faults_ff != lrupr_pkg::CNT_MAX) ? faults_ff + 1'b1 : faults_ff;
      hits_next   = (hit_ff && hits_ff != lrupr_pkg::CNT_MAX) ? hits_ff + 1'b1 : hits_ff;
   end

   always_comb begin
      state_in       = state_ff;
      frame_count_in = csr_wr_en ? csr_wr_data : frame_count_ff;
      valid_in       = valid_ff;
      clock_in       = clock_ff;
      faults_in      = faults_ff;
      hits_in        = hits_ff;
      page_in        = page_ff;
      last_in        = last_ff;
      last_idx_in    = last_idx_ff;
      idx_in         = idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      empty_in       = empty_ff;
      empty_idx_in   = empty_idx_ff;
      best_set_in    = best_set_ff;
      best_time_in   = best_time_ff;
      best_idx_in    = best_idx_ff;
      best_page_in   = best_page_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      wr_addr        = slot;
      wr_data        = {clock_next, page_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               page_in     = PAGE_BITS'(req_tdata[lrupr_pkg::REQ_PAGE_W-1:0]);
               last_in     = req_tlast;
               last_idx_in = active_last;
               idx_in      = '0;
               hit_in      = 1'b0;
               empty_in    = 1'b0;
               best_set_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = (idx_ff == last_idx_ff) ? '0 : FB'(idx_ff + 1'b1);
            if (entry_valid && entry_page == page_ff && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
            end
            if (!entry_valid && !empty_ff) begin
               empty_in     = 1'b1;
               empty_idx_in = idx_ff;
            end
            if (entry_valid && (!best_set_ff || entry_time < best_time_ff)) begin
               best_set_in  = 1'b1;
               best_time_in = entry_time;
               best_idx_in  = idx_ff;
               best_page_in = entry_page;
            end
            if (idx_ff == last_idx_ff) begin
               state_in = ST_WRITE;
            end else begin
               idx_in = FB'(idx_ff + 1'b1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               mem_we        = 1'b1;
               valid_in[slot] = 1'b1;
               clock_in      = clock_next;
               faults_in     = faults_next;
               hits_in       = hits_next;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_data_in[lrupr_pkg::RSP_HIT_LSB] = hit_ff;
               rsp_data_in[lrupr_pkg::RSP_FRAME_LSB +: lrupr_pkg::FRAME_INDEX_W] =
                  lrupr_pkg::FRAME_INDEX_W'(slot);
               rsp_data_in[lrupr_pkg::RSP_EVV_LSB] = !hit_ff && !empty_ff;
               if (!hit_ff && !empty_ff) begin
                  rsp_data_in[lrupr_pkg::RSP_EVP_LSB +: lrupr_pkg::REQ_PAGE_W] =
                     lrupr_pkg::REQ_PAGE_W'(best_page_ff);
               end
               rsp_data_in[lrupr_pkg::RSP_FAULT_LSB +: CW] = faults_next;
               rsp_data_in[lrupr_pkg::RSP_HITS_LSB +: CW]  = hits_next;
               rsp_data_in[lrupr_pkg::RSP_TSAT_LSB] = (clock_next == lrupr_pkg::CNT_MAX);
               if (last_ff) begin
                  valid_in  = '0;
                  clock_in  = '0;
                  faults_in = '0;
                  hits_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= lrupr_pkg::FRAME_COUNT_RESET;
         valid_ff       <= '0;
         clock_ff       <= '0;
         faults_ff      <= '0;
         hits_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         valid_ff       <= valid_in;
         clock_ff       <= clock_in;
         faults_ff      <= faults_in;
         hits_ff        <= hits_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      page_ff      <= page_in;
      last_ff      <= last_in;
      last_idx_ff  <= last_idx_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      empty_ff     <= empty_in;
      empty_idx_ff <= empty_idx_in;
      best_set_ff  <= best_set_in;
      best_time_ff <= best_time_in;
      best_idx_ff  <= best_idx_in;
      best_page_ff <= best_page_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- design/lrupr_checker.sv -----
// Port-level checker for the LRU page replacement unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lrupr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [lrupr_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic rsp_hit;
   logic rsp_evv;
   logic [lrupr_pkg::REQ_PAGE_W-1:0] rsp_evp;

   assign rsp_hit = rsp_tdata[lrupr_pkg::RSP_HIT_LSB];
   assign rsp_evv = rsp_tdata[lrupr_pkg::RSP_EVV_LSB];
   assign rsp_evp = rsp_tdata[lrupr_pkg::RSP_EVP_LSB +: lrupr_pkg::REQ_PAGE_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_hit && rsp_evv))
      else $error("hit reported with an eviction");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_evv |-> rsp_evp == '0)
      else $error("evicted page nonzero without eviction");

   a_no_accept_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
